// File: hdl/spd_pkg.sv
package spd_pkg;

   typedef enum logic [1:0] {
      EV_ACQ = 2'd0,
      EV_TCA = 2'd1,
      EV_LOS = 2'd2
   } event_kind_type;

   // look record: azimuth in the low bits, then elevation, then range rate
   typedef struct packed {
      logic signed [14:0] range_rate;
      logic signed [15:0] elevation;
      logic [16:0]        azimuth;
   } look_type;

   typedef struct packed {
      logic [3:0]  track;
      logic [31:0] time_tick;
      look_type    look;
   } sample_type;

   // per-track pass record; acquisition time equals the pass start time
   typedef struct packed {
      logic               peaked;
      logic signed [15:0] highest;
      logic [31:0]        start_time;
      look_type           acq_look;
      logic [31:0]        tca_time;
      look_type           tca_look;
   } track_rec_type;

   typedef struct packed {
      logic [3:0]  track;
      logic [31:0] acq_time;
      look_type    acq_look;
      logic [31:0] tca_time;
      look_type    tca_look;
      logic [31:0] los_time;
      look_type    los_look;
      logic [31:0] duration;
   } run_type;

   localparam logic [14:0] MIN_ELEV_RESET = 15'd4289;

endpackage

// File: hdl/satellite_pass_event_detector_top.sv
// Satellite pass event detector: look-angle samples in, AOS/TCA/LOS reports out.
// req channel: one sample per transaction (track index, time, elevation,
//   azimuth, range rate), valid/ready.
// rsp channel: a reported pass is a run of three transactions in order:
//   acquisition, closest approach, loss; last_of_run marks the loss entry.
// csr port: csr_write_enable writes csr_write_data into min_elevation at once.
// Throughput: one sample per cycle unless a run is held back at the output,
//   set by the single compare-and-update pass on one track record between the
//   input register and the output register. The first entry of a run is
//   presented after the loss sample passes the input register and the run is
//   loaded into the output register; the three entries go out on consecutive
//   cycles when rsp_ready stays high. A second run reaching the output while
//   one is still draining holds req_ready low until the last entry of the
//   first run is taken. A stalled receiver holds the run in the output register.
// Reset clears every track to not visible and min_elevation to 4289; the
//   per-track records need no clearing pass.
module satellite_pass_event_detector_top
   import spd_pkg::*;
#(
   parameter int TRACK_COUNT = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [14:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_track_index,
   input  logic [31:0]        req_time_tick,
   input  logic signed [15:0] req_elevation,
   input  logic [16:0]        req_azimuth,
   input  logic signed [14:0] req_range_rate,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_out_track,
   output logic [1:0]         rsp_event_kind,
   output logic [31:0]        rsp_event_time,
   output logic [16:0]        rsp_event_azimuth,
   output logic signed [15:0] rsp_event_elevation,
   output logic signed [14:0] rsp_event_range_rate,
   output logic [31:0]        rsp_pass_duration,
   output logic               rsp_last_of_run
);

   logic    run_valid;
   logic    run_ready;
   run_type run_data;

   spd_track_stage #(
      .TRACK_COUNT(TRACK_COUNT)
   ) u_track_stage (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_track_index  (req_track_index),
      .req_time_tick    (req_time_tick),
      .req_elevation    (req_elevation),
      .req_azimuth      (req_azimuth),
      .req_range_rate   (req_range_rate),
      .run_valid        (run_valid),
      .run_data         (run_data),
      .run_ready        (run_ready)
   );

   spd_event_out u_event_out (
      .clock                (clock),
      .reset                (reset),
      .run_valid            (run_valid),
      .run_data             (run_data),
      .run_ready            (run_ready),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_track        (rsp_out_track),
      .rsp_event_kind       (rsp_event_kind),
      .rsp_event_time       (rsp_event_time),
      .rsp_event_azimuth    (rsp_event_azimuth),
      .rsp_event_elevation  (rsp_event_elevation),
      .rsp_event_range_rate (rsp_event_range_rate),
      .rsp_pass_duration    (rsp_pass_duration),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

// File: hdl/spd_track_stage.sv
module spd_track_stage
   import spd_pkg::*;
#(
   parameter int TRACK_COUNT = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [14:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_track_index,
   input  logic [31:0]        req_time_tick,
   input  logic signed [15:0] req_elevation,
   input  logic [16:0]        req_azimuth,
   input  logic signed [14:0] req_range_rate,
   output logic               run_valid,
   output run_type            run_data,
   input  logic               run_ready
);

   localparam int AddrWidth = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;

   logic [14:0]            min_elev_ff, min_elev_in;
   logic                   s1_valid_ff, s1_valid_in;
   sample_type             s1_ff, s1_in;
   track_rec_type          rd_ff, rd_in;
   logic [TRACK_COUNT-1:0] visible_ff, visible_in;
   track_rec_type          track_mem [TRACK_COUNT];

   logic [8:0]             req_wide, s1_wide;
   logic [AddrWidth-1:0]   req_addr, s1_addr;
   logic                   s1_in_range;
   logic                   s1_visible;
   track_rec_type          rec_new;
   logic                   wr_need, vis_next, emit_need;
   logic                   s1_advance, accept, commit, wr_en;
   logic signed [16:0]     tca_el_wide, min_el_wide;

   assign req_wide    = {5'd0, req_track_index};
   assign req_addr    = req_wide[AddrWidth-1:0];
   assign s1_wide     = {5'd0, s1_ff.track};
   assign s1_addr     = s1_wide[AddrWidth-1:0];
   assign s1_in_range = s1_wide < 9'(TRACK_COUNT);
   assign s1_visible  = s1_in_range && visible_ff[s1_addr];

   assign tca_el_wide = {rec_new.tca_look.elevation[15], rec_new.tca_look.elevation};
   assign min_el_wide = {2'b00, min_elev_ff};

   always_comb begin
      rec_new   = rd_ff;
      wr_need   = 1'b0;
      vis_next  = s1_visible;
      emit_need = 1'b0;
      if (s1_in_range) begin
         if (!s1_visible) begin
            // acquisition: a rise above the horizon opens the pass
            if (s1_ff.look.elevation > 16'sd0) begin
               rec_new.peaked     = 1'b0;
               rec_new.highest    = 16'sd0;
               rec_new.start_time = s1_ff.time_tick;
               rec_new.acq_look   = s1_ff.look;
               wr_need            = 1'b1;
               vis_next           = 1'b1;
            end
         end else begin
            wr_need = 1'b1;
            if (s1_ff.look.elevation > rd_ff.highest) begin
               rec_new.highest = s1_ff.look.elevation;
            end else if (!rd_ff.peaked) begin
               rec_new.peaked   = 1'b1;
               rec_new.tca_time = s1_ff.time_tick;
               rec_new.tca_look = s1_ff.look;
            end
            if (s1_ff.look.elevation < 16'sd0) begin
               vis_next  = 1'b0;
               emit_need = tca_el_wide >= min_el_wide;
            end
         end
      end
   end

   always_comb begin
      run_data.track    = s1_ff.track;
      run_data.acq_time = rd_ff.start_time;
      run_data.acq_look = rd_ff.acq_look;
      run_data.tca_time = rec_new.tca_time;
      run_data.tca_look = rec_new.tca_look;
      run_data.los_time = s1_ff.time_tick;
      run_data.los_look = s1_ff.look;
      run_data.duration = s1_ff.time_tick - rd_ff.start_time;
   end

   assign run_valid  = s1_valid_ff && emit_need;
   assign s1_advance = !run_valid || run_ready;
   assign req_ready  = s1_advance;
   assign accept     = req_valid && req_ready;
   assign commit     = s1_valid_ff && s1_advance;
   assign wr_en      = commit && wr_need;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      visible_in = visible_ff;
      if (commit && s1_in_range) begin
         visible_in[s1_addr] = vis_next;
      end

      min_elev_in = csr_write_enable ? csr_write_data : min_elev_ff;

      s1_in.track           = req_track_index;
      s1_in.time_tick       = req_time_tick;
      s1_in.look.azimuth    = req_azimuth;
      s1_in.look.elevation  = req_elevation;
      s1_in.look.range_rate = req_range_rate;

      // same-track write in this cycle wins over the stored record
      rd_in = (wr_en && s1_addr == req_addr) ? rec_new : track_mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         visible_ff  <= '0;
         min_elev_ff <= MIN_ELEV_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         visible_ff  <= visible_in;
         min_elev_ff <= min_elev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         track_mem[s1_addr] <= rec_new;
      end
      if (accept) begin
         rd_ff <= rd_in;
         s1_ff <= s1_in;
      end
   end

endmodule

// File: hdl/spd_event_out.sv
module spd_event_out
   import spd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               run_valid,
   input  run_type            run_data,
   output logic               run_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_out_track,
   output logic [1:0]         rsp_event_kind,
   output logic [31:0]        rsp_event_time,
   output logic [16:0]        rsp_event_azimuth,
   output logic signed [15:0] rsp_event_elevation,
   output logic signed [14:0] rsp_event_range_rate,
   output logic [31:0]        rsp_pass_duration,
   output logic               rsp_last_of_run
);

   run_type        run_ff;
   logic           out_valid_ff, out_valid_in;
   event_kind_type beat_ff, beat_in;
   look_type       look_sel;
   logic           take;

   assign take      = out_valid_ff && rsp_ready;
   assign run_ready = !out_valid_ff || (rsp_ready && beat_ff == EV_LOS);

   always_comb begin
      out_valid_in = out_valid_ff;
      beat_in      = beat_ff;
      if (run_valid && run_ready) begin
         out_valid_in = 1'b1;
         beat_in      = EV_ACQ;
      end else if (take) begin
         case (beat_ff)
            EV_ACQ:  beat_in = EV_TCA;
            EV_TCA:  beat_in = EV_LOS;
            default: begin
               beat_in      = EV_ACQ;
               out_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         beat_ff      <= EV_ACQ;
      end else begin
         out_valid_ff <= out_valid_in;
         beat_ff      <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (run_valid && run_ready) begin
         run_ff <= run_data;
      end
   end

   always_comb begin
      case (beat_ff)
         EV_ACQ: begin
            rsp_event_time    = run_ff.acq_time;
            look_sel          = run_ff.acq_look;
            rsp_pass_duration = 32'd0;
         end
         EV_TCA: begin
            rsp_event_time    = run_ff.tca_time;
            look_sel          = run_ff.tca_look;
            rsp_pass_duration = run_ff.duration;
         end
         default: begin
            rsp_event_time    = run_ff.los_time;
            look_sel          = run_ff.los_look;
            rsp_pass_duration = run_ff.duration;
         end
      endcase
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_out_track        = run_ff.track;
   assign rsp_event_kind       = beat_ff;
   assign rsp_event_azimuth    = look_sel.azimuth;
   assign rsp_event_elevation  = look_sel.elevation;
   assign rsp_event_range_rate = look_sel.range_rate;
   assign rsp_last_of_run      = beat_ff == EV_LOS;

endmodule

// File: hdl/spd_checker.sv
module spd_checker
   import spd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_out_track,
   input logic [1:0]  rsp_event_kind,
   input logic [31:0] rsp_pass_duration,
   input logic        rsp_last_of_run
);

   // the loss entry and only the loss entry closes a run
   a_last_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_run == (rsp_event_kind == EV_LOS)))
      else $error("last_of_run does not match event kind");

   a_acq_zero_duration: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_ACQ) |-> (rsp_pass_duration == 32'd0))
      else $error("acquisition entry with nonzero duration");

   // a run is never cut short: acquisition is followed by closest approach
   a_acq_then_tca: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_event_kind == EV_ACQ) |=>
      (rsp_valid && rsp_event_kind == EV_TCA && $stable(rsp_out_track)))
      else $error("closest approach entry missing after acquisition");

   a_tca_then_los: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_event_kind == EV_TCA) |=>
      (rsp_valid && rsp_event_kind == EV_LOS && $stable(rsp_out_track)
       && $stable(rsp_pass_duration)))
      else $error("loss entry missing or changed after closest approach");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind satellite_pass_event_detector_top spd_checker u_spd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_track     (rsp_out_track),
   .rsp_event_kind    (rsp_event_kind),
   .rsp_pass_duration (rsp_pass_duration),
   .rsp_last_of_run   (rsp_last_of_run)
);

// File: verif/satellite_pass_event_detector_top_test.sv
module satellite_pass_event_detector_top_test;
   import spd_pkg::*;

   localparam int TRACKS        = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 150;
   localparam int SETTLE_CYCLES = 4;

   typedef enum int {GEN_BELOW, GEN_RISING, GEN_FALLING} gen_phase_type;

   typedef struct packed {
      logic [3:0]     track;
      event_kind_type kind;
      logic [31:0]    ev_time;
      look_type       look;
      logic [31:0]    duration;
      logic           last;
   } pass_report_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [14:0]        csr_write_data   = MIN_ELEV_RESET;
   logic               req_valid        = 1'b0;
   logic [3:0]         req_track_index  = '0;
   logic [31:0]        req_time_tick    = '0;
   logic signed [15:0] req_elevation    = '0;
   logic [16:0]        req_azimuth      = '0;
   logic signed [14:0] req_range_rate   = '0;
   logic               rsp_ready        = 1'b0;

   logic               req_ready;
   logic               rsp_valid;
   logic [3:0]         rsp_out_track;
   logic [1:0]         rsp_event_kind;
   logic [31:0]        rsp_event_time;
   logic [16:0]        rsp_event_azimuth;
   logic signed [15:0] rsp_event_elevation;
   logic signed [14:0] rsp_event_range_rate;
   logic [31:0]        rsp_pass_duration;
   logic               rsp_last_of_run;

   // pass tracker state, mirrored per track
   logic [14:0]        min_elev_model;
   logic               trk_visible   [TRACKS];
   logic               trk_peaked    [TRACKS];
   logic signed [15:0] trk_highest   [TRACKS];
   logic [31:0]        trk_start     [TRACKS];
   logic [31:0]        trk_acq_time  [TRACKS];
   look_type           trk_acq_look  [TRACKS];
   logic [31:0]        trk_tca_time  [TRACKS];
   look_type           trk_tca_look  [TRACKS];

   pass_report_type    expected_reports[$];

   // random pass shaping per track
   gen_phase_type      gen_phase [TRACKS];
   int                 gen_el    [TRACKS];
   logic [31:0]        gen_time  [TRACKS];
   logic [31:0]        pass_clock = 32'd20000;

   int errors          = 0;
   int samples_sent    = 0;
   int reports_checked = 0;
   int settings_used   = 0;
   int cycle_count     = 0;
   int hold_requests   = 0;
   int hold_seen       = 0;
   int hold_left       = 0;
   bit quiet           = 1'b0;

   satellite_pass_event_detector_top DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_track_index     (req_track_index),
      .req_time_tick       (req_time_tick),
      .req_elevation       (req_elevation),
      .req_azimuth         (req_azimuth),
      .req_range_rate      (req_range_rate),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_track       (rsp_out_track),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_event_time      (rsp_event_time),
      .rsp_event_azimuth   (rsp_event_azimuth),
      .rsp_event_elevation (rsp_event_elevation),
      .rsp_event_range_rate(rsp_event_range_rate),
      .rsp_pass_duration   (rsp_pass_duration),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d pass events still outstanding", $time,
                  expected_reports.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls, quiet stretches, and long hold-offs on request
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 24);
      end
   end

   function automatic pass_report_type make_report(input int trk, input event_kind_type kind,
                                                   input logic [31:0] t, input look_type look,
                                                   input logic [31:0] dur, input logic last);
      pass_report_type r;
      r.track    = trk[3:0];
      r.kind     = kind;
      r.ev_time  = t;
      r.look     = look;
      r.duration = dur;
      r.last     = last;
      return r;
   endfunction

   function automatic sample_type make_sample(input int trk, input logic [31:0] t,
                                              input int el, input int az, input int rr);
      sample_type s;
      s.track           = trk[3:0];
      s.time_tick       = t;
      s.look.elevation  = el[15:0];
      s.look.azimuth    = az[16:0];
      s.look.range_rate = rr[14:0];
      return s;
   endfunction

   task automatic predict_pass_events(input sample_type s);
      int                 k;
      logic signed [15:0] el;
      logic [31:0]        dur;
      k  = s.track;
      el = s.look.elevation;
      if (!trk_visible[k]) begin
         if (el > 0) begin
            trk_acq_time[k] = s.time_tick;
            trk_acq_look[k] = s.look;
            trk_highest[k]  = '0;
            trk_start[k]    = s.time_tick;
            trk_visible[k]  = 1'b1;
            trk_peaked[k]   = 1'b0;
         end
         return;
      end
      if (el > trk_highest[k]) begin
         trk_highest[k] = el;
      end else if (!trk_peaked[k]) begin
         // first sample that fails to rise marks closest approach
         trk_peaked[k]   = 1'b1;
         trk_tca_time[k] = s.time_tick;
         trk_tca_look[k] = s.look;
      end
      if (el >= 0)
         return;
      trk_visible[k] = 1'b0;
      if ($signed(trk_tca_look[k].elevation) < $signed({1'b0, min_elev_model}))
         return;
      dur = s.time_tick - trk_start[k];
      expected_reports = {expected_reports,
                          make_report(k, EV_ACQ, trk_acq_time[k], trk_acq_look[k],
                                      32'd0, 1'b0)};
      expected_reports = {expected_reports,
                          make_report(k, EV_TCA, trk_tca_time[k], trk_tca_look[k],
                                      dur, 1'b0)};
      expected_reports = {expected_reports,
                          make_report(k, EV_LOS, s.time_tick, s.look, dur, 1'b1)};
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      pass_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none, actual track %0d kind %0d",
                     $time, rsp_out_track, rsp_event_kind);
         end else begin
            want = expected_reports.pop_front();
            check_field("out_track", {28'b0, want.track}, {28'b0, rsp_out_track});
            check_field("event_kind", {30'b0, want.kind}, {30'b0, rsp_event_kind});
            check_field("event_time", want.ev_time, rsp_event_time);
            check_field("event_azimuth", {15'b0, want.look.azimuth},
                        {15'b0, rsp_event_azimuth});
            check_field("event_elevation", {16'b0, want.look.elevation},
                        {16'b0, rsp_event_elevation});
            check_field("event_range_rate", {17'b0, want.look.range_rate},
                        {17'b0, rsp_event_range_rate});
            check_field("pass_duration", want.duration, rsp_pass_duration);
            check_field("last_of_run", {31'b0, want.last}, {31'b0, rsp_last_of_run});
            reports_checked++;
         end
      end
   end

   // called at a rising edge; returns at the edge where the transaction completes
   task automatic send_sample(input sample_type s);
      if (!quiet)
         while ($urandom_range(99) < 24) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid       <= 1'b1;
      req_track_index <= s.track;
      req_time_tick   <= s.time_tick;
      req_elevation   <= s.look.elevation;
      req_azimuth     <= s.look.azimuth;
      req_range_rate  <= s.look.range_rate;
      do @(posedge clock); while (!req_ready);
      predict_pass_events(s);
      samples_sent++;
   endtask

   task automatic drain_outstanding;
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      // samples that end no pass may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_min_elevation(input logic [14:0] value);
      drain_outstanding();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      min_elev_model = value;
      settings_used++;
   endtask

   // one complete pass whose closest approach sits at tca_el when tca_el is not negative
   task automatic send_pass(input int trk, input int tca_el);
      pass_clock += $urandom_range(1, 200);
      send_sample(make_sample(trk, pass_clock, 1, $urandom_range(102943),
                              int'($urandom_range(32000)) - 16000));
      if (tca_el > 0) begin
         repeat (2) begin
            pass_clock += $urandom_range(1, 200);
            send_sample(make_sample(trk, pass_clock, tca_el, $urandom_range(102943),
                                    int'($urandom_range(32000)) - 16000));
         end
      end else if (tca_el == 0) begin
         pass_clock += $urandom_range(1, 200);
         send_sample(make_sample(trk, pass_clock, 0, $urandom_range(102943), 0));
      end
      pass_clock += $urandom_range(1, 200);
      send_sample(make_sample(trk, pass_clock, -1 - int'($urandom_range(100)),
                              $urandom_range(102943), int'($urandom_range(32000)) - 16000));
   endtask

   task automatic send_random_samples(input int count);
      int k;
      int el;
      int az;
      int rr;
      repeat (count) begin
         k = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(TRACKS - 1);
         gen_time[k] += $urandom_range(1, 300);
         if ($urandom_range(99) < 2)
            gen_time[k] = $urandom;
         az = ($urandom_range(99) < 8) ? $urandom_range(17'h1FFFF) : $urandom_range(102943);
         rr = ($urandom_range(99) < 8) ? int'($urandom_range(15'h7FFF))
                                       : int'($urandom_range(32000)) - 16000;
         if ($urandom_range(99) < 8) begin
            // raw noise, any 16-bit pattern
            el = $urandom_range(16'hFFFF);
         end else begin
            case (gen_phase[k])
               GEN_BELOW: begin
                  if ($urandom_range(99) < 15) begin
                     el = -int'($urandom_range(25736));
                  end else begin
                     el = $urandom_range(1, 3000);
                     gen_phase[k] = GEN_RISING;
                  end
               end
               GEN_RISING: begin
                  if ($urandom_range(99) < 30) begin
                     el = gen_el[k] - int'($urandom_range(3000));
                     gen_phase[k] = GEN_FALLING;
                  end else begin
                     el = gen_el[k] + int'($urandom_range(1, 6000));
                  end
                  if (el > 25736)
                     el = 25736;
               end
               default: begin
                  el = gen_el[k] - int'($urandom_range(6000));
                  if (el < 0 || $urandom_range(99) < 20) begin
                     el = -int'($urandom_range(1, 25736));
                     gen_phase[k] = GEN_BELOW;
                  end
               end
            endcase
            gen_el[k] = el;
         end
         send_sample(make_sample(k, gen_time[k], el, az, rr));
      end
   endtask

   task automatic test_directed_cases;
      // zero elevation is no rise; widest azimuth and range rate on the way
      send_sample(make_sample(0, 32'd50, 0, 100, 0));
      send_sample(make_sample(0, 32'd100, 1, 0, -16000));
      send_sample(make_sample(0, 32'd200, 25736, 102943, 16000));
      send_sample(make_sample(0, 32'd300, 25000, 1, 0));
      send_sample(make_sample(0, 32'd400, -1, 51471, -1));
      // time wraps inside the pass, closest approach exactly at the minimum
      send_sample(make_sample(15, 32'hFFFF_FFF0, 100, 17'h1FFFF, 16383));
      send_sample(make_sample(15, 32'hFFFF_FFF8, 5000, 200, -300));
      send_sample(make_sample(15, 32'hFFFF_FFFF, 4289, 300, -200));
      send_sample(make_sample(15, 32'h0000_0010, -25736, 400, 100));
      // closest approach one below the minimum ends silently
      send_sample(make_sample(3, 32'd1000, 100, 10, 10));
      send_sample(make_sample(3, 32'd1001, 4300, 20, 20));
      send_sample(make_sample(3, 32'd1002, 4288, 30, 30));
      send_sample(make_sample(3, 32'd1003, -5, 40, 40));
      // raw extremes of elevation and range rate
      send_sample(make_sample(6, 32'd2000, 32767, 0, -16384));
      send_sample(make_sample(6, 32'd2001, -32768, 17'h1FFFF, 16383));
      // equal sample latches closest approach, later rise does not move it
      send_sample(make_sample(9, 32'd3000, 2000, 500, 1));
      send_sample(make_sample(9, 32'd3010, 9000, 600, 2));
      send_sample(make_sample(9, 32'd3020, 9000, 700, 3));
      send_sample(make_sample(9, 32'd3030, 12000, 800, 4));
      send_sample(make_sample(9, 32'd3040, -1, 900, 5));
   endtask

   task automatic test_min_elevation_extremes;
      int levels[4];
      levels = '{0, 25736, 32767, $urandom_range(1, 25735)};
      foreach (levels[i]) begin
         set_min_elevation(levels[i][14:0]);
         send_pass(7, levels[i]);
         send_pass(8, levels[i] - 1);
         send_random_samples(10);
      end
   endtask

   task automatic test_backpressure;
      logic [31:0] t;
      t = 32'd5000;
      // every pass below clears the minimum so the output fills up
      set_min_elevation(MIN_ELEV_RESET);
      quiet = 1'b1;
      hold_requests++;
      for (int trk = 12; trk < TRACKS; trk++) begin
         // close whatever pass random traffic left open on this track
         send_sample(make_sample(trk, t, -1, 0, 0));
         send_sample(make_sample(trk, t + 10, 300, 1000, -500));
         send_sample(make_sample(trk, t + 20, 20000, 2000, -100));
         send_sample(make_sample(trk, t + 30, 19000, 3000, 100));
         send_sample(make_sample(trk, t + 40, -100, 4000, 500));
         t += 100;
      end
      // sender pauses here until every report has drained
      drain_outstanding();
      quiet = 1'b0;
   endtask

   task automatic test_random_traffic;
      set_min_elevation(MIN_ELEV_RESET);
      send_random_samples(55);
      set_min_elevation(15'($urandom_range(1000, 8000)));
      quiet = 1'b1;
      send_random_samples(55);
      quiet = 1'b0;
      set_min_elevation(15'd12000);
      send_random_samples(55);
      set_min_elevation(15'($urandom_range(25736)));
      send_random_samples(55);
   endtask

   initial begin
      min_elev_model = MIN_ELEV_RESET;
      for (int k = 0; k < TRACKS; k++) begin
         trk_visible[k]  = 1'b0;
         trk_peaked[k]   = 1'b0;
         trk_highest[k]  = '0;
         trk_start[k]    = '0;
         trk_acq_time[k] = '0;
         trk_acq_look[k] = '0;
         trk_tca_time[k] = '0;
         trk_tca_look[k] = '0;
         gen_phase[k]    = GEN_BELOW;
         gen_el[k]       = 0;
         gen_time[k]     = $urandom;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_min_elevation_extremes();
      test_backpressure();
      test_random_traffic();
      drain_outstanding();

      $display("covered %0d samples, %0d pass events checked, %0d min_elevation settings",
               samples_sent, reports_checked, settings_used);
      $display("including time wrap, raw extremes, held-off receiver and quiet streaming");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/spd_pkg.sv
hdl/spd_track_stage.sv
hdl/spd_event_out.sv
hdl/satellite_pass_event_detector_top.sv
hdl/spd_checker.sv
verif/satellite_pass_event_detector_top_test.sv
